@@ design/dqms_pkg.sv @@
package dqms_pkg;

  // Default queue depth
  localparam int CAPACITY_DEF = 16;

  // Field widths
  localparam int DATA_W = 32;
  localparam int FUNC_W = 3;
  localparam int STAT_W = 2;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR      = 3'd4;
  localparam logic [FUNC_W-1:0] FN_SEARCH     = 3'd5;
  localparam logic [FUNC_W-1:0] FN_LIST_FWD   = 3'd6;
  localparam logic [FUNC_W-1:0] FN_LIST_BWD   = 3'd7;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

endpackage

@@ design/deque_with_membership_search.sv @@
// Bounded double-ended queue of signed 32-bit values with membership search.
// Input channel (in_valid / in_stall / in_func / in_item_value) takes one
// operation per item: push front/back, pop front/back, clear, search, or a
// listing front to back or back to front. Result channel (out_valid /
// out_stall / out_*) returns one item per operation, or one item per stored
// value for a listing, with out_last_result on the final one.
// Sequence: push, pop and clear pass from accept through the EXEC and DONE
// states to the result; a search walks the stored values in the WALK state
// before DONE, and a listing returns each value straight from WALK.
// The pace of a walk is set by the single registered read port of the entry
// memory: one entry per cycle, while the result side does not stall a listing.
// One operation is in flight at a time: in_stall is high from accept until
// the last result has been loaded into the output register.
// Reset clears the front pointer, the count and all handshake state; the
// entry memory is not cleared and is only ever read inside the occupied
// window. A stall on the result side holds the output register and pauses
// the walk without losing or repeating any item.
module deque_with_membership_search import dqms_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [FUNC_W-1:0]                   in_func,
  input  logic signed [DATA_W-1:0]            in_item_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [STAT_W-1:0]                   out_status,
  output logic                                out_found,
  output logic signed [DATA_W-1:0]            out_value,
  output logic                                out_has_value,
  output logic                                out_last_result,
  output logic [$clog2(CAPACITY+1)-1:0]       out_entry_count
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  // Circular index: the sum is always below twice the capacity
  function automatic logic [IDX_W-1:0] wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] t;
    t = s;
    if (s >= SUM_W'(CAPACITY)) begin
      t = s - SUM_W'(CAPACITY);
    end
    return t[IDX_W-1:0];
  endfunction

  logic [1:0]               state_r, state_nxt;
  logic [FUNC_W-1:0]        func_r;
  logic signed [DATA_W-1:0] value_r;
  logic [IDX_W-1:0]         head_r, head_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         rd_cnt_r, rd_cnt_nxt;
  logic [CNT_W-1:0]         cons_cnt_r, cons_cnt_nxt;
  logic                     pend_r, pend_nxt;
  logic [STAT_W-1:0]        res_status_r, res_status_nxt;
  logic                     res_found_r, res_found_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]        out_status_r, out_status_nxt;
  logic                     out_found_r, out_found_nxt;
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  logic                     out_has_r, out_has_nxt;
  logic                     out_last_r, out_last_nxt;
  logic [CNT_W-1:0]         out_cnt_r, out_cnt_nxt;

  // Entry memory, one write and one registered read port
  logic signed [DATA_W-1:0] mem [CAPACITY];
  logic signed [DATA_W-1:0] rd_data_r;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  logic                     rd_en;
  logic [IDX_W-1:0]         rd_addr;

  logic             in_take;
  logic             out_free;
  logic             is_list;
  logic [CNT_W-1:0] rd_off;
  logic             hit;
  logic             cons_last;
  logic             consume;
  logic             walk_end;
  logic             load_out;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign is_list  = (func_r == FN_LIST_FWD) || (func_r == FN_LIST_BWD);

  // Walk address: offset from the front, mirrored for a backward listing
  assign rd_off  = (func_r == FN_LIST_BWD) ? (count_r - rd_cnt_r - CNT_W'(1)) : rd_cnt_r;
  assign rd_addr = wrap(SUM_W'(head_r) + SUM_W'(rd_off));

  assign hit       = pend_r && (rd_data_r == value_r);
  assign cons_last = (cons_cnt_r == count_r - CNT_W'(1));

  // Walk control: reads run ahead by one entry at most
  always_comb begin
    consume  = 1'b0;
    walk_end = 1'b0;
    if (state_r == S_WALK) begin
      if (is_list) begin
        consume  = pend_r && out_free;
        walk_end = consume && cons_last;
      end else begin
        consume  = pend_r;
        walk_end = hit || (consume && cons_last);
      end
    end
  end

  assign rd_en = (state_r == S_WALK) && (rd_cnt_r != count_r) &&
                 (!pend_r || consume) && !walk_end;

  // Main sequencer
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    rd_cnt_nxt     = rd_cnt_r;
    cons_cnt_nxt   = cons_cnt_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    wr_en          = 1'b0;
    wr_addr        = head_r;
    load_out       = 1'b0;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_value_nxt  = out_value_r;
    out_has_nxt    = out_has_r;
    out_last_nxt   = out_last_r;
    out_cnt_nxt    = out_cnt_r;

    // read data flag
    if (walk_end) begin
      pend_nxt = 1'b0;
    end else if (rd_en) begin
      pend_nxt = 1'b1;
    end else if (consume) begin
      pend_nxt = 1'b0;
    end else begin
      pend_nxt = pend_r;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_nxt = ST_OK;
        res_found_nxt  = 1'b0;
        rd_cnt_nxt     = '0;
        cons_cnt_nxt   = '0;
        state_nxt      = S_DONE;
        case (func_r) inside
          FN_PUSH_FRONT, FN_PUSH_BACK: begin
            if (count_r == CAP_CNT) begin
              res_status_nxt = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + CNT_W'(1);
              if (func_r == FN_PUSH_FRONT) begin
                head_nxt = (head_r == '0) ? IDX_LAST : head_r - IDX_W'(1);
                wr_addr  = head_nxt;
              end else begin
                wr_addr = wrap(SUM_W'(head_r) + SUM_W'(count_r));
              end
            end
          end
          FN_POP_FRONT, FN_POP_BACK: begin
            if (count_r == '0) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              count_nxt = count_r - CNT_W'(1);
              if (func_r == FN_POP_FRONT) begin
                head_nxt = wrap(SUM_W'(head_r) + SUM_W'(1));
              end
            end
          end
          FN_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
            // search and listing walk the occupied window
            if (count_r != '0) begin
              state_nxt = S_WALK;
            end
          end
        endcase
      end
      S_WALK: begin
        if (rd_en) begin
          rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
        end
        if (consume) begin
          cons_cnt_nxt = cons_cnt_r + CNT_W'(1);
        end
        if (is_list) begin
          if (consume) begin
            load_out       = 1'b1;
            out_status_nxt = ST_OK;
            out_found_nxt  = 1'b0;
            out_value_nxt  = rd_data_r;
            out_has_nxt    = 1'b1;
            out_last_nxt   = cons_last;
            out_cnt_nxt    = count_r;
          end
          if (walk_end) begin
            state_nxt = S_IDLE;
          end
        end else if (walk_end) begin
          res_found_nxt = hit;
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          load_out       = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          out_value_nxt  = '0;
          out_has_nxt    = 1'b0;
          out_last_nxt   = 1'b1;
          out_cnt_nxt    = count_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = load_out ? 1'b1 : (out_valid_r && out_stall);
  end

  // Memory: writes happen only in EXEC, reads only in WALK, so they never overlap
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= value_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      func_r  <= in_func;
      value_r <= in_item_value;
    end
    rd_cnt_r     <= rd_cnt_nxt;
    cons_cnt_r   <= cons_cnt_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_value_r  <= out_value_nxt;
    out_has_r    <= out_has_nxt;
    out_last_r   <= out_last_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_value       = out_value_r;
  assign out_has_value   = out_has_r;
  assign out_last_result = out_last_r;
  assign out_entry_count = out_cnt_r;

endmodule

@@ design/dqms_check.sv @@
module dqms_check import dqms_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [STAT_W-1:0]             out_status,
  input logic                          out_found,
  input logic signed [DATA_W-1:0]      out_value,
  input logic                          out_has_value,
  input logic                          out_last_result,
  input logic [$clog2(CAPACITY+1)-1:0] out_entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // A stalled result item holds its value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) &&
    $stable(out_last_result))
    else $error("result item changed while stalled");

  // A refused push only happens on a full queue
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> (out_entry_count == CNT_W'(CAPACITY)))
    else $error("full status with free entries");

  // A refused pop only happens on an empty queue
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> (out_entry_count == '0))
    else $error("empty status with stored entries");

  // A listed value never comes from an empty queue and is never a search hit
  a_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_value |->
    (out_entry_count != '0) && !out_found && (out_status == ST_OK))
    else $error("bad listing item");

  // Count never exceeds the capacity
  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count <= CNT_W'(CAPACITY)))
    else $error("entry count beyond capacity");

endmodule

bind deque_with_membership_search dqms_check #(.CAPACITY(CAPACITY)) u_dqms_check (.*);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import dqms_pkg::*;

  localparam int DEPTH = CAPACITY_DEF;
  localparam int CNT_W = $clog2(CAPACITY_DEF + 1);
  localparam int RANDOM_ITEMS = 420;

  // One result item as seen on the out_ ports
  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic                     found;
    logic signed [DATA_W-1:0] value;
    logic                     has_value;
    logic                     last;
    logic [CNT_W-1:0]         count;
  } deque_result_t;

  // Directed stimulus row; typed rows carry their expected single result
  typedef struct {
    logic [FUNC_W-1:0]        fn;
    logic signed [DATA_W-1:0] val;
    int                       reps;
    bit                       typed;
    logic [STAT_W-1:0]        t_status;
    logic                     t_found;
    logic [CNT_W-1:0]         t_count;
  } directed_row_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_RUNS} stall_mode_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [FUNC_W-1:0]        in_func = FN_PUSH_FRONT;
  logic signed [DATA_W-1:0] in_item_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STAT_W-1:0]        out_status;
  logic                     out_found;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_has_value;
  logic                     out_last_result;
  logic [CNT_W-1:0]         out_entry_count;

  deque_with_membership_search DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_value       (out_value),
    .out_has_value   (out_has_value),
    .out_last_result (out_last_result),
    .out_entry_count (out_entry_count)
  );

  // Shadow deque state
  logic signed [DATA_W-1:0] dq_mem [DEPTH];
  int                       dq_head = 0;
  int                       dq_count = 0;

  deque_result_t owed_results [$];
  directed_row_t directed_rows [$];
  int            fail_cnt = 0;
  int            burst_left = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Apply one operation to the shadow deque; queue its results if asked
  function automatic void apply_deque_op(input logic [FUNC_W-1:0] fn,
                                         input logic signed [DATA_W-1:0] val,
                                         input bit record);
    deque_result_t r;
    int            k;
    r = '0;
    r.last = 1'b1;
    case (fn)
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        if (dq_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (fn == FN_PUSH_FRONT) begin
            dq_head = (dq_head + DEPTH - 1) % DEPTH;
            dq_mem[dq_head] = val;
          end else begin
            dq_mem[(dq_head + dq_count) % DEPTH] = val;
          end
          dq_count++;
        end
      end
      FN_POP_FRONT, FN_POP_BACK: begin
        if (dq_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (fn == FN_POP_FRONT) dq_head = (dq_head + 1) % DEPTH;
          dq_count--;
        end
      end
      FN_CLEAR: dq_count = 0;
      FN_SEARCH: begin
        for (k = 0; k < dq_count; k++)
          if (dq_mem[(dq_head + k) % DEPTH] == val) r.found = 1'b1;
      end
      default: begin
        // listings: one item per stored value, or a lone empty item
        if (dq_count > 0) begin
          for (k = 0; k < dq_count; k++) begin
            r.value = (fn == FN_LIST_FWD) ? dq_mem[(dq_head + k) % DEPTH]
                                          : dq_mem[(dq_head + dq_count - 1 - k) % DEPTH];
            r.has_value = 1'b1;
            r.last = (k == dq_count - 1);
            r.count = CNT_W'(dq_count);
            if (record) owed_results.push_back(r);
          end
          return;
        end
      end
    endcase
    r.count = CNT_W'(dq_count);
    if (record) owed_results.push_back(r);
  endfunction

  // A mix of stored entries, extremes, small values near zero and raw noise
  function automatic logic signed [DATA_W-1:0] pick_value();
    int                       sel;
    logic signed [DATA_W-1:0] v;
    sel = $urandom_range(0, 15);
    if (sel < 4 && dq_count > 0) begin
      v = dq_mem[(dq_head + $urandom_range(0, dq_count - 1)) % DEPTH];
    end else if (sel < 6) begin
      case ($urandom_range(0, 3))
        0: v = 32'sh7fffffff;
        1: v = 32'sh80000000;
        2: v = '0;
        default: v = -1;
      endcase
    end else if (sel < 10) begin
      v = $urandom_range(0, 15);
      v = v - 8;
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  task automatic add_row(input logic [FUNC_W-1:0] fn, input logic signed [DATA_W-1:0] val,
                         input int reps, input bit typed, input logic [STAT_W-1:0] st,
                         input logic fd, input logic [CNT_W-1:0] cnt);
    directed_row_t r;
    r.fn = fn;
    r.val = val;
    r.reps = reps;
    r.typed = typed;
    r.t_status = st;
    r.t_found = fd;
    r.t_count = cnt;
    directed_rows.push_back(r);
  endtask

  // Present one item and return at the edge that accepts it
  task automatic send_op(input logic [FUNC_W-1:0] fn, input logic signed [DATA_W-1:0] val);
    in_valid <= 1'b1;
    in_func <= fn;
    in_item_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Burst/gap pacing on the input side
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 14);
    end
  endtask

  // Hold off the input until every owed result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_results.size() != 0);
  endtask

  // Stimulus
  initial begin
    directed_row_t            row;
    deque_result_t            typed_want;
    logic [FUNC_W-1:0]        fn;
    logic signed [DATA_W-1:0] val;
    int                       n;
    int                       k;
    int                       pick;
    int                       phase_left;
    bit                       filling;

    // after reset: empty listing, pops and search on an empty deque
    add_row(FN_LIST_FWD,   '0,            1,  1, ST_OK,    1'b0, 0);
    add_row(FN_POP_FRONT,  '0,            1,  1, ST_EMPTY, 1'b0, 0);
    add_row(FN_POP_BACK,   -1,            1,  1, ST_EMPTY, 1'b0, 0);
    add_row(FN_SEARCH,     '0,            1,  1, ST_OK,    1'b0, 0);
    // extremes; push front from head 0 wraps to the top slot
    add_row(FN_PUSH_BACK,  32'sh7fffffff, 1,  1, ST_OK,    1'b0, 1);
    add_row(FN_PUSH_FRONT, 32'sh80000000, 1,  1, ST_OK,    1'b0, 2);
    add_row(FN_SEARCH,     32'sh80000000, 1,  1, ST_OK,    1'b1, 2);
    add_row(FN_SEARCH,     32'sh7ffffffe, 1,  1, ST_OK,    1'b0, 2);
    // fill to capacity from both ends
    add_row(FN_PUSH_BACK,  100,           7,  0, ST_OK,    1'b0, 0);
    add_row(FN_PUSH_FRONT, -100,          7,  0, ST_OK,    1'b0, 0);
    add_row(FN_PUSH_BACK,  5,             1,  1, ST_FULL,  1'b0, 16);
    add_row(FN_PUSH_FRONT, 5,             1,  1, ST_FULL,  1'b0, 16);
    add_row(FN_LIST_FWD,   '0,            1,  0, ST_OK,    1'b0, 0);
    add_row(FN_LIST_BWD,   '0,            1,  0, ST_OK,    1'b0, 0);
    add_row(FN_SEARCH,     106,           1,  0, ST_OK,    1'b0, 0);
    add_row(FN_POP_FRONT,  '0,            1,  1, ST_OK,    1'b0, 15);
    add_row(FN_POP_BACK,   '0,            1,  1, ST_OK,    1'b0, 14);
    add_row(FN_SEARCH,     32'sh7fffffff, 1,  0, ST_OK,    1'b0, 0);
    // clear keeps the head; the deque is empty again
    add_row(FN_CLEAR,      '0,            1,  1, ST_OK,    1'b0, 0);
    add_row(FN_LIST_BWD,   '0,            1,  1, ST_OK,    1'b0, 0);
    add_row(FN_POP_BACK,   '0,            1,  1, ST_EMPTY, 1'b0, 0);
    add_row(FN_PUSH_FRONT, 32'sh55555555, 1,  1, ST_OK,    1'b0, 1);
    add_row(FN_LIST_FWD,   '0,            1,  0, ST_OK,    1'b0, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      for (k = 0; k < row.reps; k++) begin
        val = row.val + k;
        send_op(row.fn, val);
        if (row.typed) begin
          apply_deque_op(row.fn, val, 1'b0);
          typed_want = '0;
          typed_want.status = row.t_status;
          typed_want.found = row.t_found;
          typed_want.last = 1'b1;
          typed_want.count = row.t_count;
          owed_results.push_back(typed_want);
        end else begin
          apply_deque_op(row.fn, val, 1'b1);
        end
        pace_sender();
      end
    end
    drain_results();

    // random part, alternating fill-heavy and drain-heavy phases
    filling = 1'b1;
    phase_left = $urandom_range(25, 60);
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain_results();
      if (phase_left == 0 || (filling && dq_count == DEPTH && $urandom_range(0, 3) == 0)
          || (!filling && dq_count == 0)) begin
        filling = !filling;
        phase_left = $urandom_range(25, 60);
      end
      phase_left--;
      pick = $urandom_range(0, 99);
      if (pick < (filling ? 45 : 15))
        fn = $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
      else if (pick < 60)
        fn = $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
      else if (pick < 78)
        fn = FN_SEARCH;
      else if (pick < 88)
        fn = FN_LIST_FWD;
      else if (pick < 97)
        fn = FN_LIST_BWD;
      else
        fn = FN_CLEAR;
      val = pick_value();
      send_op(fn, val);
      apply_deque_op(fn, val, 1'b1);
      pace_sender();
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  task automatic flag_result(input string why, input deque_result_t want,
                             input deque_result_t got);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display("%0t %s: want st=%0d fd=%0d val=%0d hv=%0d last=%0d cnt=%0d | got st=%0d fd=%0d val=%0d hv=%0d last=%0d cnt=%0d",
               $time, why, want.status, want.found, want.value, want.has_value, want.last,
               want.count, got.status, got.found, got.value, got.has_value, got.last,
               got.count);
  endtask

  // Result checking and receiver stall pattern
  stall_mode_t   stall_mode = STALL_NONE;
  int            mode_left = 0;
  int            run_left = 0;
  bit            run_stalled = 1'b0;
  bit            next_stall;
  deque_result_t got_result;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_result = {out_status, out_found, out_value, out_has_value, out_last_result,
                    out_entry_count};
      if (owed_results.size() == 0)
        flag_result("unexpected result item", '0, got_result);
      else if (got_result !== owed_results[0])
        flag_result("result mismatch", owed_results.pop_front(), got_result);
      else
        void'(owed_results.pop_front());
    end

    if (mode_left == 0) begin
      case ($urandom_range(0, 2))
        0: stall_mode = STALL_NONE;
        1: stall_mode = STALL_COIN;
        default: stall_mode = STALL_RUNS;
      endcase
      mode_left = $urandom_range(16, 120);
    end
    mode_left--;
    case (stall_mode)
      STALL_NONE: next_stall = 1'b0;
      STALL_COIN: next_stall = $urandom_range(0, 1);
      default: begin
        if (run_left == 0) begin
          run_stalled = !run_stalled;
          run_left = run_stalled ? $urandom_range(2, 8) : $urandom_range(1, 6);
        end
        run_left--;
        next_stall = run_stalled;
      end
    endcase
    out_stall <= rst_n ? next_stall : 1'b0;
  end

endmodule
